[rtl/slpc_pkg.sv]
`default_nettype none

package slpc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned CODE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [THRESH_W-1:0] SHORT_THRESH_RST = 16'd50;
    localparam logic [THRESH_W-1:0] LONG_THRESH_RST  = 16'd1000;

    // Release classification codes.
    localparam logic [CODE_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [CODE_W-1:0] KIND_LONG  = 2'd2;

    // Beep request codes: a short beep lasts 100 ms, a long one 500 ms.
    localparam logic [CODE_W-1:0] BEEP_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] BEEP_SHORT = 2'd1;
    localparam logic [CODE_W-1:0] BEEP_LONG  = 2'd2;

    typedef struct packed {
        logic                pressed_level;
        logic [THRESH_W-1:0] short_threshold_ms;
        logic [THRESH_W-1:0] long_threshold_ms;
        logic                notify_enable;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/short_long_press_classifier.sv]
`default_nettype none

// Short/long button press classifier.
//
// Input channel (in_valid, in_stall, pin_level, now_ms): one item is one
// sample of the button pin with its millisecond timestamp. An item is taken
// at a clock edge where in_valid is high and in_stall is low.
// Output channel (out_valid, out_stall, press_kind, beep_request): exactly one
// result item per input item, in order. press_kind reports a released short or
// long press, and beep_request asks for a short (100 ms) or long (500 ms) beep
// while the button is held.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
// pressed level, both thresholds and the notify enable. It is always ready;
// the user must write it only while no item is in flight, as the block itself does not enforce this.
// From the accepting edge to out_valid, the input register takes the item,
// and a subtract, two compares and the flag logic feed the result register
// when it is free. One item is taken every cycle while the receiver does not
// stall; the press-time and beep-flag feedback closes through the press
// state registers alone. When the receiver stalls, the result register holds
// and the input register can still take one more item before in_stall rises.
// Reset clears both valid flags, the press state and loads the register
// defaults (pressed level 0, thresholds 50 and 1000 ms, notify disabled).
module short_long_press_classifier
    import slpc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 pin_level,
    input  wire logic [TIME_W-1:0]    now_ms,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [CODE_W-1:0]         press_kind,
    output logic [CODE_W-1:0]         beep_request,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THRESH_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    // Input register stage.
    logic              in_valid_reg;
    logic              level_reg;
    logic [TIME_W-1:0] now_reg;

    // Press tracking state.
    logic              prev_level_reg;
    logic [TIME_W-1:0] press_start_reg;
    logic              long_armed_reg;
    logic              short_armed_reg;

    logic              prev_level_next;
    logic [TIME_W-1:0] press_start_next;
    logic              long_armed_next;
    logic              short_armed_next;

    // Result register stage.
    logic              out_valid_reg;
    logic [CODE_W-1:0] kind_reg;
    logic [CODE_W-1:0] beep_reg;
    logic [CODE_W-1:0] kind_next;
    logic [CODE_W-1:0] beep_next;

    logic              advance;
    logic              take_in;
    logic [TIME_W-1:0] held;
    logic              over_long;
    logic              over_short;
    logic              level_change;
    logic              is_pressed;

    // The result register frees up when empty or when its item is taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressed_level      <= 1'b0;
            cfg_reg.short_threshold_ms <= SHORT_THRESH_RST;
            cfg_reg.long_threshold_ms  <= LONG_THRESH_RST;
            cfg_reg.notify_enable      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PRESSED_LEVEL: cfg_reg.pressed_level      <= cfg_data[0];
                CFG_SHORT_THRESH:  cfg_reg.short_threshold_ms <= cfg_data;
                CFG_LONG_THRESH:   cfg_reg.long_threshold_ms  <= cfg_data;
                CFG_NOTIFY_EN:     cfg_reg.notify_enable      <= cfg_data[0];
                default:           cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            level_reg <= pin_level;
            now_reg   <= now_ms;
        end
    end

    // Hold time since the last press or release edge, modulo 2^32. On a step
    // where the level does not change this is also the hold time the beep
    // logic needs. Beeps are decided only on a step where the level does not
    // change, and on a release edge the pin is not pressed either, so neither
    // edge can request a beep.
    assign held         = now_reg - press_start_reg;
    assign over_long    = held > {{(TIME_W-THRESH_W){1'b0}}, cfg_reg.long_threshold_ms};
    assign over_short   = held > {{(TIME_W-THRESH_W){1'b0}}, cfg_reg.short_threshold_ms};
    assign level_change = level_reg != prev_level_reg;
    assign is_pressed   = level_reg == cfg_reg.pressed_level;

    always_comb
    begin
        prev_level_next  = prev_level_reg;
        press_start_next = press_start_reg;
        long_armed_next  = long_armed_reg;
        short_armed_next = short_armed_reg;
        kind_next        = KIND_NONE;
        beep_next        = BEEP_NONE;

        if (level_change)
        begin
            prev_level_next  = level_reg;
            press_start_next = now_reg;
            if (is_pressed)
            begin
                long_armed_next  = 1'b1;
                short_armed_next = 1'b1;
            end
            else if (over_long)
            begin
                kind_next = KIND_LONG;
            end
            else if (over_short)
            begin
                kind_next = KIND_SHORT;
            end
        end
        else if (cfg_reg.notify_enable && is_pressed)
        begin
            // The long beep wins; once given, a later sample may still give
            // the short beep if that flag is still armed.
            if (over_long && long_armed_reg)
            begin
                beep_next       = BEEP_LONG;
                long_armed_next = 1'b0;
            end
            else if (over_short && short_armed_reg)
            begin
                beep_next        = BEEP_SHORT;
                short_armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b0;
            press_start_reg <= '0;
            long_armed_reg  <= 1'b0;
            short_armed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                prev_level_reg  <= prev_level_next;
                press_start_reg <= press_start_next;
                long_armed_reg  <= long_armed_next;
                short_armed_reg <= short_armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            kind_reg <= kind_next;
            beep_reg <= beep_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign press_kind   = kind_reg;
    assign beep_request = beep_reg;

endmodule

`default_nettype wire

[verif/tb_short_long_press_classifier.sv]
`default_nettype none

// Testbench for the short/long press classifier.
//
// Every accepted input item is run through a local prediction of the press
// logic, and the expected result item is queued. A checker process pops the
// oldest expectation for each accepted result item and compares both fields.
// The stimulus starts with a few hand-picked press/release sequences around
// the thresholds, then runs randomized press sequences and noise under
// several register settings and idle/stall mixes, and ends with a long
// receiver hold-off that backs the block up into its input.
module tb_short_long_press_classifier;

    import slpc_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int CLK_PERIOD = 2 * CLK_HALF;
    // Far above the slowest legal run, even with both sides idling most of the time.
    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    // Longest idle gap the sender inserts in front of one item.
    localparam int MAX_SEND_GAP = 40;
    // Extra wait at the end, after every result item is out.
    localparam int SETTLE_CYCLES = 8;

    // One result item as it appears on the output port.
    typedef struct packed {
        logic [CODE_W-1:0] kind;
        logic [CODE_W-1:0] beep;
    } press_result_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 pin_level    = 1'b0;
    logic [TIME_W-1:0]    now_ms       = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [CODE_W-1:0]    press_kind;
    logic [CODE_W-1:0]    beep_request;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [THRESH_W-1:0]  cfg_data     = '0;

    short_long_press_classifier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .press_kind   (press_kind),
        .beep_request (beep_request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Local copy of the block's registers and press state.
    cfg_t              model_cfg;
    logic              seen_level;
    logic [TIME_W-1:0] press_start;
    logic              long_armed;
    logic              short_armed;

    // Expected result items, oldest first.
    press_result_t pending_results[$];

    int mismatch_count = 0;
    int items_sent     = 0;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int send_idle_pct  = 0;
    int out_stall_pct  = 0;
    // Cycles left in a forced receiver hold-off.
    int hold_left      = 0;

    // Running millisecond clock used to build press sequences.
    logic [TIME_W-1:0] ms_clock;

    // Predicts the result item for one accepted sample and advances the
    // local press state the same way the block must.
    function automatic press_result_t classify_sample(input logic level,
                                                      input logic [TIME_W-1:0] stamp);
        press_result_t     r;
        logic [TIME_W-1:0] held;
        r.kind = KIND_NONE;
        r.beep = BEEP_NONE;
        if (level != seen_level)
        begin
            seen_level = level;
            if (level == model_cfg.pressed_level)
            begin
                // A new press restarts the timer and arms both beeps.
                press_start = stamp;
                long_armed  = 1'b1;
                short_armed = 1'b1;
            end
            else
            begin
                // Hold time wraps modulo 2^32, like the timestamp itself.
                held        = stamp - press_start;
                press_start = stamp;
                if (held > TIME_W'(model_cfg.long_threshold_ms))
                    r.kind = KIND_LONG;
                else if (held > TIME_W'(model_cfg.short_threshold_ms))
                    r.kind = KIND_SHORT;
            end
        end
        if (model_cfg.notify_enable && level == model_cfg.pressed_level)
        begin
            held = stamp - press_start;
            // The long beep wins when both are due; the short one can still
            // follow on a later held sample.
            if (held > TIME_W'(model_cfg.long_threshold_ms) && long_armed)
            begin
                r.beep     = BEEP_LONG;
                long_armed = 1'b0;
            end
            else if (held > TIME_W'(model_cfg.short_threshold_ms) && short_armed)
            begin
                r.beep      = BEEP_SHORT;
                short_armed = 1'b0;
            end
        end
        return r;
    endfunction

    // Receiver side: random stalls, or a forced hold-off while hold_left
    // counts down.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    // Result checker. Values read here are those from just before the edge,
    // so the stall seen is the one the block saw.
    press_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with none expected: press_kind %0d beep_request %0d",
                         $time, press_kind, beep_request);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (press_kind !== want.kind)
                begin
                    $display("%0t: press_kind expected %0d actual %0d",
                             $time, want.kind, press_kind);
                    mismatch_count++;
                end
                if (beep_request !== want.beep)
                begin
                    $display("%0t: beep_request expected %0d actual %0d",
                             $time, want.beep, beep_request);
                    mismatch_count++;
                end
            end
        end
    end

    // Offers one sample and returns once it has been taken. Valid is left
    // high so that a following item can go out back to back; it only drops
    // when a gap is drawn or the input is paused.
    task automatic send_sample(input logic level, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (!in_valid)
            in_valid <= 1'b1;
        pin_level <= level;
        now_ms    <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(classify_sample(level, stamp));
        items_sent++;
    endtask

    task automatic pause_input();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the input paused and every result
    // item delivered, so no item is in flight when a setting changes.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [THRESH_W-1:0] data);
        pause_input();
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_PRESSED_LEVEL: model_cfg.pressed_level      = data[0];
            CFG_SHORT_THRESH:  model_cfg.short_threshold_ms = data;
            CFG_LONG_THRESH:   model_cfg.long_threshold_ms  = data;
            CFG_NOTIFY_EN:     model_cfg.notify_enable      = data[0];
            default:           ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all four registers. The one-bit registers get random upper
    // data bits, which the block must ignore.
    task automatic load_settings(input logic level, input logic [THRESH_W-1:0] short_ms,
                                 input logic [THRESH_W-1:0] long_ms, input logic notify);
        logic [THRESH_W-1:0] d;
        d    = THRESH_W'($urandom());
        d[0] = level;
        write_register(CFG_PRESSED_LEVEL, d);
        write_register(CFG_SHORT_THRESH, short_ms);
        write_register(CFG_LONG_THRESH, long_ms);
        d    = THRESH_W'($urandom());
        d[0] = notify;
        write_register(CFG_NOTIFY_EN, d);
    endtask

    // Hold times cluster on the threshold edges, where off-by-one errors
    // in the compares would show.
    function automatic logic [TIME_W-1:0] pick_hold();
        logic [TIME_W-1:0] sh;
        logic [TIME_W-1:0] lg;
        logic [TIME_W-1:0] h;
        sh = TIME_W'(model_cfg.short_threshold_ms);
        lg = TIME_W'(model_cfg.long_threshold_ms);
        case ($urandom_range(0, 7))
            0:       h = sh;
            1:       h = sh + 1;
            2:       h = lg;
            3:       h = lg + 1;
            4:       h = $urandom_range(0, sh + 2);
            5:       h = $urandom_range(0, lg + lg / 2 + 2);
            6:       h = $urandom();
            default: h = $urandom_range(0, 3);
        endcase
        return h;
    endfunction

    // A well-formed press: some released samples, the press, a few held
    // samples spread over the hold time, then the release.
    task automatic send_press_sequence();
        logic              down;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] t0;
        int                n_held;
        down = model_cfg.pressed_level;
        repeat ($urandom_range(0, 2))
        begin
            ms_clock = ms_clock + $urandom_range(0, 300);
            send_sample(~down, ms_clock);
        end
        hold_ms  = pick_hold();
        ms_clock = ms_clock + $urandom_range(1, 100);
        t0       = ms_clock;
        send_sample(down, t0);
        n_held = $urandom_range(0, 6);
        for (int i = 1; i <= n_held; i++)
            send_sample(down, t0 + (hold_ms / (n_held + 1)) * i + $urandom_range(0, 1));
        ms_clock = t0 + hold_ms;
        send_sample(~down, ms_clock);
    endtask

    task automatic run_random_phase(input int n_items, input int idle_pct,
                                    input int stall_pct);
        int first;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        first         = items_sent;
        // Some phases start just below the timestamp wrap.
        if ($urandom_range(0, 3) == 0)
            ms_clock = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
        else
            ms_clock = $urandom();
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
                send_press_sequence();
            else
                repeat ($urandom_range(1, 4))
                    send_sample(1'($urandom_range(0, 1)), $urandom());
        end
    endtask

    // With the reset settings, the first release measures from time zero,
    // then presses land just past and just on the short threshold and just past the long one.
    task automatic test_release_timing();
        send_sample(1'b1, 32'd5000);
        send_sample(1'b0, 32'd5000);
        send_sample(1'b1, 32'd5051);
        send_sample(1'b0, 32'd6000);
        send_sample(1'b1, 32'd6050);
        send_sample(1'b0, 32'd7000);
        send_sample(1'b1, 32'd8001);
    endtask

    // Beeps while held: short past its threshold, long past its own, and a
    // short beep that still follows when the long one fired first. Releases
    // never beep.
    task automatic test_beep_requests();
        write_register(CFG_NOTIFY_EN, THRESH_W'(1));
        send_sample(1'b0, 32'd20000);
        send_sample(1'b0, 32'd20050);
        send_sample(1'b0, 32'd20051);
        send_sample(1'b0, 32'd21000);
        send_sample(1'b0, 32'd21001);
        send_sample(1'b1, 32'd21002);
        send_sample(1'b0, 32'd30000);
        send_sample(1'b0, 32'd31500);
        send_sample(1'b0, 32'd31501);
        send_sample(1'b1, 32'd31502);
    endtask

    // Thresholds at both ends of their range, a high pressed level, and
    // holds that straddle the timestamp wrap.
    task automatic test_threshold_extremes();
        load_settings(1'b1, 16'd0, 16'hFFFF, 1'b1);
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b0, 32'h0001_0000);
        load_settings(1'b1, 16'hFFFF, 16'd0, 1'b1);
        send_sample(1'b1, 32'h0001_0000);
        send_sample(1'b1, 32'h0001_0001);
        send_sample(1'b1, 32'h0002_0000);
        send_sample(1'b1, 32'h0002_0001);
        send_sample(1'b0, 32'h0002_0001);
    endtask

    task automatic test_random_traffic();
        load_settings(1'b0, 16'($urandom_range(0, 500)), 16'($urandom_range(0, 3000)), 1'b1);
        run_random_phase(360, 0, 0);
        load_settings(1'b1, 16'd0, 16'hFFFF, 1'b1);
        run_random_phase(360, 79, 0);
        load_settings(1'b0, 16'hFFFF, 16'd0, 1'b1);
        run_random_phase(360, 0, 79);
        load_settings(1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()), 1'b0);
        run_random_phase(360, 8, 8);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block fills and stalls its input.
    // Once every result item is out, more presses run under random stalls.
    task automatic test_backpressure();
        load_settings(1'b0, 16'($urandom_range(0, 200)), 16'($urandom_range(200, 1500)), 1'b1);
        send_idle_pct = 0;
        out_stall_pct = 0;
        ms_clock      = $urandom();
        hold_left     = 300;
        repeat (8)
            send_press_sequence();
        pause_input();
        drain_results();
        out_stall_pct = 30;
        repeat (6)
            send_press_sequence();
    endtask

    initial
    begin
        model_cfg.pressed_level      = 1'b0;
        model_cfg.short_threshold_ms = SHORT_THRESH_RST;
        model_cfg.long_threshold_ms  = LONG_THRESH_RST;
        model_cfg.notify_enable      = 1'b0;
        seen_level  = 1'b0;
        press_start = '0;
        long_armed  = 1'b0;
        short_armed = 1'b0;
        ms_clock    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        out_stall_pct = 20;
        test_release_timing();
        test_beep_requests();
        test_threshold_extremes();
        test_random_traffic();
        test_backpressure();

        pause_input();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/slpc_pkg.sv
rtl/short_long_press_classifier.sv
verif/tb_short_long_press_classifier.sv
